### hdl/dlcs_pkg.sv
package dlcs_pkg;

   // Fixed field widths.
   localparam int PIX_BITS        = 8;
   localparam int TALLY_BITS      = 25;
   localparam int SUM_BITS        = 37;
   localparam int SECTION_BITS    = 2;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 13;
   localparam int WIDTH_REG_BITS  = 13;
   localparam int LEVEL_REG_BITS  = 8;
   localparam int TOL_REG_BITS    = 11;
   localparam int BOUND_REG_BITS  = 13;

   // Default coordinate width (column and row counters).
   localparam int COORD_BITS_DEFAULT = 12;

   // Register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] REG_ROW_PIXELS         = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DARK_LEVEL         = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CENTER_TOLERANCE   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ROW_LIMIT          = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COL_LOW            = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COL_HIGH           = 3'd5;

   // Register reset values.
   localparam logic [WIDTH_REG_BITS-1:0] ROW_PIXELS_RESET       = 13'd640;
   localparam logic [LEVEL_REG_BITS-1:0] DARK_LEVEL_RESET       = 8'd30;
   localparam logic [TOL_REG_BITS-1:0]   CENTER_TOLERANCE_RESET = 11'd15;
   localparam logic [BOUND_REG_BITS-1:0] ROW_LIMIT_RESET        = 13'd96;
   localparam logic [BOUND_REG_BITS-1:0] COL_LOW_RESET          = 13'd192;
   localparam logic [BOUND_REG_BITS-1:0] COL_HIGH_RESET         = 13'd448;

   // Steering codes.
   localparam logic [SECTION_BITS-1:0] SEC_LEFT     = 2'd0;
   localparam logic [SECTION_BITS-1:0] SEC_STRAIGHT = 2'd1;
   localparam logic [SECTION_BITS-1:0] SEC_RIGHT    = 2'd2;
   localparam logic [SECTION_BITS-1:0] SEC_SEARCH   = 2'd3;

   // Frame totals handed from the accumulator to the decision pipeline.
   typedef struct packed {
      logic [TALLY_BITS-1:0] tally;
      logic [SUM_BITS-1:0]   sum;
   } frame_totals_type;

endpackage

### hdl/dark_line_centroid_steering.sv
// A frame_end word goes from the input register through the snapshot, product and result stages.
// Throughput: one pixel word per cycle; ordinary pixels pass even while a result waits.
// A frame_end word stalls only when the three-stage decision pipeline is full.
// Reset (synchronous, active high) clears all valid bits, counters and frame totals
// and restores every configuration register to its default value.
module dark_line_centroid_steering #(
   parameter int COORD_BITS = dlcs_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Pixel input channel.
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [dlcs_pkg::PIX_BITS-1:0]         req_blue,
   input  logic [dlcs_pkg::PIX_BITS-1:0]         req_green,
   input  logic [dlcs_pkg::PIX_BITS-1:0]         req_red,
   input  logic                                  req_frame_end,
   // Steering result channel.
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [dlcs_pkg::SECTION_BITS-1:0]     rsp_section,
   output logic [dlcs_pkg::TALLY_BITS-1:0]       rsp_dark_count,
   // Configuration write port.
   input  logic                                  csr_wen,
   input  logic [dlcs_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [dlcs_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   // Configuration registers.
   logic [dlcs_pkg::WIDTH_REG_BITS-1:0] row_pixels_ff;
   logic [dlcs_pkg::LEVEL_REG_BITS-1:0] dark_level_ff;
   logic [dlcs_pkg::TOL_REG_BITS-1:0]   center_tol_ff;
   logic [dlcs_pkg::BOUND_REG_BITS-1:0] row_limit_ff;
   logic [dlcs_pkg::BOUND_REG_BITS-1:0] col_low_ff;
   logic [dlcs_pkg::BOUND_REG_BITS-1:0] col_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pixels_ff  <= dlcs_pkg::ROW_PIXELS_RESET;
         dark_level_ff  <= dlcs_pkg::DARK_LEVEL_RESET;
         center_tol_ff  <= dlcs_pkg::CENTER_TOLERANCE_RESET;
         row_limit_ff   <= dlcs_pkg::ROW_LIMIT_RESET;
         col_low_ff     <= dlcs_pkg::COL_LOW_RESET;
         col_high_ff    <= dlcs_pkg::COL_HIGH_RESET;
      end else if (csr_wen) begin
         // Indexes outside the register list are ignored.
         unique case (csr_index)
            dlcs_pkg::REG_ROW_PIXELS: begin
               row_pixels_ff <= csr_wdata[dlcs_pkg::WIDTH_REG_BITS-1:0];
            end
            dlcs_pkg::REG_DARK_LEVEL: begin
               dark_level_ff <= csr_wdata[dlcs_pkg::LEVEL_REG_BITS-1:0];
            end
            dlcs_pkg::REG_CENTER_TOLERANCE: begin
               center_tol_ff <= csr_wdata[dlcs_pkg::TOL_REG_BITS-1:0];
            end
            dlcs_pkg::REG_ROW_LIMIT: begin
               row_limit_ff <= csr_wdata[dlcs_pkg::BOUND_REG_BITS-1:0];
            end
            dlcs_pkg::REG_COL_LOW: begin
               col_low_ff <= csr_wdata[dlcs_pkg::BOUND_REG_BITS-1:0];
            end
            dlcs_pkg::REG_COL_HIGH: begin
               col_high_ff <= csr_wdata[dlcs_pkg::BOUND_REG_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Input register stage. The pixel held here is classified and added to the
   // frame totals in the cycle it leaves. A word without frame_end always
   // leaves at once; a frame_end word leaves when the decision pipeline can
   // take the frame totals.
   logic                                a_valid_ff, a_valid_in;
   logic [dlcs_pkg::PIX_BITS-1:0]       a_blue_ff;
   logic [dlcs_pkg::PIX_BITS-1:0]       a_green_ff;
   logic [dlcs_pkg::PIX_BITS-1:0]       a_red_ff;
   logic                                a_last_ff;

   logic                                req_accept;
   logic                                a_move;
   logic                                snap_ready;
   dlcs_pkg::frame_totals_type          totals;
   logic [COORD_BITS-1:0]               half_width;

   assign a_move     = a_valid_ff && (!a_last_ff || snap_ready);
   assign req_ready  = !a_valid_ff || a_move;
   assign req_accept = req_valid && req_ready;
   assign a_valid_in = req_accept ? 1'b1 : (a_move ? 1'b0 : a_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_blue_ff  <= req_blue;
         a_green_ff <= req_green;
         a_red_ff   <= req_red;
         a_last_ff  <= req_frame_end;
      end
   end

   // Raster position, dark-pixel classification and the saturating totals.
   dlcs_frame_acc #(
      .COORD_BITS (COORD_BITS)
   ) u_frame_acc (
      .clock       (clock),
      .reset       (reset),
      .step        (a_move),
      .blue        (a_blue_ff),
      .green       (a_green_ff),
      .red         (a_red_ff),
      .frame_end   (a_last_ff),
      .row_pixels  (row_pixels_ff),
      .dark_level  (dark_level_ff),
      .row_limit   (row_limit_ff),
      .col_low     (col_low_ff),
      .col_high    (col_high_ff),
      .totals      (totals),
      .half_width  (half_width)
   );

   // Snapshot, bound products and the centroid comparison. The comparison is
   // done by cross-multiplication: sum against (half width -/+ tolerance)
   // times count, so no divider is needed. The output register of this
   // pipeline holds the result word until the consumer takes it.
   dlcs_decide #(
      .COORD_BITS (COORD_BITS)
   ) u_decide (
      .clock          (clock),
      .reset          (reset),
      .snap_valid     (a_valid_ff && a_last_ff),
      .snap_ready     (snap_ready),
      .snap_totals    (totals),
      .snap_half      (half_width),
      .snap_tol       (center_tol_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_section    (rsp_section),
      .rsp_dark_count (rsp_dark_count)
   );

endmodule

### hdl/dlcs_frame_acc.sv
module dlcs_frame_acc #(
   parameter int COORD_BITS = dlcs_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  step,
   input  logic [dlcs_pkg::PIX_BITS-1:0]         blue,
   input  logic [dlcs_pkg::PIX_BITS-1:0]         green,
   input  logic [dlcs_pkg::PIX_BITS-1:0]         red,
   input  logic                                  frame_end,
   input  logic [dlcs_pkg::WIDTH_REG_BITS-1:0]   row_pixels,
   input  logic [dlcs_pkg::LEVEL_REG_BITS-1:0]   dark_level,
   input  logic [dlcs_pkg::BOUND_REG_BITS-1:0]   row_limit,
   input  logic [dlcs_pkg::BOUND_REG_BITS-1:0]   col_low,
   input  logic [dlcs_pkg::BOUND_REG_BITS-1:0]   col_high,
   output dlcs_pkg::frame_totals_type            totals,
   output logic [COORD_BITS-1:0]                 half_width
);

   // Compare width: wide enough for the width register and for 2^COORD_BITS.
   localparam int XW = ((COORD_BITS + 1 > dlcs_pkg::WIDTH_REG_BITS) ?
                        COORD_BITS + 1 : dlcs_pkg::WIDTH_REG_BITS) + 1;
   localparam int SW = dlcs_pkg::SUM_BITS + 1;
   localparam int TB = dlcs_pkg::TALLY_BITS;
   localparam logic [XW-1:0] W_CAP = {{(XW-1){1'b0}}, 1'b1} << COORD_BITS;

   logic [COORD_BITS-1:0] col_ff, col_in;
   logic [COORD_BITS-1:0] row_ff, row_in;
   logic [TB-1:0]         tally_ff, tally_in;
   logic [SW-2:0]         sum_ff, sum_in;

   logic [XW-1:0] width_x;
   logic [XW-1:0] eff_width;
   logic [XW-1:0] col_x;
   logic [XW-1:0] row_x;
   logic          dark;
   logic          kept;
   logic [TB-1:0] tally_upd;
   logic [SW-1:0] sum_wide;
   logic [SW-2:0] sum_upd;

   always_comb begin
      width_x = XW'(row_pixels);
      if (width_x == '0) begin
         eff_width = XW'(1);
      end else if (width_x > W_CAP) begin
         eff_width = W_CAP;
      end else begin
         eff_width = width_x;
      end
      half_width = eff_width[COORD_BITS:1];

      col_x = XW'(col_ff);
      row_x = XW'(row_ff);
      dark  = (blue <= dark_level) && (green <= dark_level) && (red <= dark_level);
      kept  = (row_x < XW'(row_limit)) && (col_x >= XW'(col_low)) &&
              (col_x < XW'(col_high));

      tally_upd = tally_ff;
      sum_wide  = SW'(sum_ff) + SW'(col_ff);
      sum_upd   = sum_ff;
      if (dark && kept) begin
         if (tally_ff != '1) begin
            tally_upd = tally_ff + TB'(1);
         end
         sum_upd = sum_wide[SW-1] ? '1 : sum_wide[SW-2:0];
      end
      totals.tally = tally_upd;
      totals.sum   = sum_upd;

      col_in   = col_ff;
      row_in   = row_ff;
      tally_in = tally_ff;
      sum_in   = sum_ff;
      if (step) begin
         if (frame_end) begin
            // The frame's totals leave with this word; start the next frame.
            col_in   = '0;
            row_in   = '0;
            tally_in = '0;
            sum_in   = '0;
         end else begin
            tally_in = tally_upd;
            sum_in   = sum_upd;
            if (col_x + XW'(1) >= eff_width) begin
               col_in = '0;
               if (row_ff != '1) begin
                  row_in = row_ff + COORD_BITS'(1);
               end
            end else begin
               col_in = col_ff + COORD_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         tally_ff <= '0;
         sum_ff   <= '0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         tally_ff <= tally_in;
         sum_ff   <= sum_in;
      end
   end

endmodule

### hdl/dlcs_decide.sv
module dlcs_decide #(
   parameter int COORD_BITS = dlcs_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  snap_valid,
   output logic                                  snap_ready,
   input  dlcs_pkg::frame_totals_type            snap_totals,
   input  logic [COORD_BITS-1:0]                 snap_half,
   input  logic [dlcs_pkg::TOL_REG_BITS-1:0]     snap_tol,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [dlcs_pkg::SECTION_BITS-1:0]     rsp_section,
   output logic [dlcs_pkg::TALLY_BITS-1:0]       rsp_dark_count
);

   localparam int HW = ((COORD_BITS > dlcs_pkg::TOL_REG_BITS) ?
                        COORD_BITS : dlcs_pkg::TOL_REG_BITS) + 1;
   localparam int TB = dlcs_pkg::TALLY_BITS;
   localparam int PW = HW + TB;

   // Snapshot stage.
   logic                          b_valid_ff, b_valid_in;
   dlcs_pkg::frame_totals_type    b_tot_ff;
   logic [COORD_BITS-1:0]         b_half_ff;
   logic [dlcs_pkg::TOL_REG_BITS-1:0] b_tol_ff;

   // Product stage.
   logic                          c_valid_ff, c_valid_in;
   logic                          c_lo_ok_ff, c_lo_ok_in;
   logic [PW-1:0]                 c_lo_prod_ff, c_lo_prod_in;
   logic [PW-1:0]                 c_hi_prod_ff, c_hi_prod_in;
   dlcs_pkg::frame_totals_type    c_tot_ff;

   // Result stage.
   logic                          d_valid_ff, d_valid_in;
   logic [dlcs_pkg::SECTION_BITS-1:0] d_section_ff, d_section_in;
   logic [TB-1:0]                 d_count_ff;

   logic          d_free, c_move, c_free, b_move, b_load;
   logic [HW-1:0] half_x, tol_x;
   logic [PW-1:0] sum_x;

   assign d_free     = !d_valid_ff || rsp_ready;
   assign c_move     = c_valid_ff && d_free;
   assign c_free     = !c_valid_ff || d_free;
   assign b_move     = b_valid_ff && c_free;
   assign snap_ready = !b_valid_ff || c_free;
   assign b_load     = snap_valid && snap_ready;

   always_comb begin
      b_valid_in = b_load ? 1'b1 : (b_move ? 1'b0 : b_valid_ff);
      c_valid_in = b_move ? 1'b1 : (c_move ? 1'b0 : c_valid_ff);
      d_valid_in = c_move ? 1'b1 : ((d_valid_ff && rsp_ready) ? 1'b0 : d_valid_ff);

      // Bounds times count; a left bound at or below zero never selects left.
      half_x       = HW'(b_half_ff);
      tol_x        = HW'(b_tol_ff);
      c_lo_ok_in   = half_x > tol_x;
      c_lo_prod_in = PW'(half_x - tol_x) * PW'(b_tot_ff.tally);
      c_hi_prod_in = PW'(half_x + tol_x) * PW'(b_tot_ff.tally);

      sum_x = PW'(c_tot_ff.sum);
      priority if (c_tot_ff.tally == '0) begin
         d_section_in = dlcs_pkg::SEC_SEARCH;
      end else if (c_lo_ok_ff && (sum_x < c_lo_prod_ff)) begin
         d_section_in = dlcs_pkg::SEC_LEFT;
      end else if (sum_x > c_hi_prod_ff) begin
         d_section_in = dlcs_pkg::SEC_RIGHT;
      end else begin
         d_section_in = dlcs_pkg::SEC_STRAIGHT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_load) begin
         b_tot_ff  <= snap_totals;
         b_half_ff <= snap_half;
         b_tol_ff  <= snap_tol;
      end
      if (b_move) begin
         c_lo_ok_ff   <= c_lo_ok_in;
         c_lo_prod_ff <= c_lo_prod_in;
         c_hi_prod_ff <= c_hi_prod_in;
         c_tot_ff     <= b_tot_ff;
      end
      if (c_move) begin
         d_section_ff <= d_section_in;
         d_count_ff   <= c_tot_ff.tally;
      end
   end

   assign rsp_valid      = d_valid_ff;
   assign rsp_section    = d_section_ff;
   assign rsp_dark_count = d_count_ff;

endmodule
